@@ rtl/b64cf_pkg.sv @@
`timescale 1ns / 1ps
package b64cf_pkg;

   localparam int SRC_SIGN_POS = 63;
   localparam logic [2:0] REG_TOTAL_BITS = 3'd0;
   localparam logic [2:0] REG_EXPONENT_BITS = 3'd1;
   localparam logic [2:0] REG_MANTISSA_BITS = 3'd2;
   localparam logic [2:0] REG_EXPONENT_BIAS = 3'd3;
   localparam logic [2:0] REG_ROUNDING_MODE = 3'd4;
   localparam logic [62:0] B64_INF_MAG = 63'h7FF0000000000000;
   localparam logic [62:0] B64_QNAN_MAG = 63'h7FF8000000000000;

   typedef enum logic [1:0] {
      KIND_FINITE,
      KIND_NAN,
      KIND_ZERO,
      KIND_SAT
   } kind_type;

   typedef enum logic [2:0] {
      RM_RNE = 3'd0,
      RM_RTZ = 3'd1,
      RM_RDN = 3'd2,
      RM_RUP = 3'd3,
      RM_RMM = 3'd4
   } mode_type;

   typedef struct packed {
      logic [6:0]  tb;
      logic [3:0]  e;
      logic [5:0]  m;
      logic [10:0] bias;
      mode_type    mode;
   } cfg_type;

   typedef struct packed {
      logic               sign;
      kind_type           kind;
      logic [52:0]        mm;
      logic signed [12:0] i;
      logic               sub;
      logic [5:0]         sh;
   } dec_type;

   typedef struct packed {
      logic               sign;
      kind_type           kind;
      logic [63:0]        target;
      logic               exact;
      logic [52:0]        mant;
      logic signed [12:0] xe;
   } rnd_type;

   function automatic logic [10:0] all_ones(input logic [3:0] e);
      return 11'((12'd1 << e) - 12'd1);
   endfunction

   function automatic logic [63:0] sign_at(input logic s, input logic [6:0] tb);
      return {63'd0, s} << (tb - 7'd1);
   endfunction

endpackage

@@ rtl/b64cf_decode.sv @@
`timescale 1ns / 1ps
module b64cf_decode import b64cf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        in_valid,
   output logic        in_stall,
   input  logic [63:0] in_bits,
   output logic        out_valid,
   input  logic        out_stall,
   output dec_type     out_dec
);

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_sign_ff;
   logic [10:0] s1_be_ff;
   logic [51:0] s1_fr_ff;
   logic [5:0]  s1_n_ff, s1_n_in;
   logic        s2_valid_ff, s2_valid_in;
   dec_type     s2_ff, s2_in;
   logic        s1_adv, s2_adv;
   logic [5:0]  msb;

   logic               nan_c, zero_c, inf_c;
   logic [10:0]        expones;
   logic signed [12:0] bias13, thr, lo, i_c;

   assign s2_adv = !s2_valid_ff || !out_stall;
   assign s1_adv = !s1_valid_ff || s2_adv;
   assign in_stall = !s1_adv;
   assign out_valid = s2_valid_ff;
   assign out_dec = s2_ff;

   always_comb begin
      msb = 6'd0;
      for (int b = 0; b < 52; b++) begin
         if (in_bits[b]) begin
            msb = 6'(b);
         end
      end
      s1_n_in = 6'd52 - msb;
      s1_valid_in = s1_adv ? in_valid : s1_valid_ff;
      s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;
   end

   always_comb begin
      nan_c = (s1_be_ff == 11'h7FF) && (s1_fr_ff != 52'd0);
      zero_c = (s1_be_ff == 11'd0) && (s1_fr_ff == 52'd0);
      inf_c = (s1_be_ff == 11'h7FF);
      expones = all_ones(cfg.e);
      bias13 = $signed({2'b00, cfg.bias});
      thr = $signed({2'b00, expones}) - bias13;
      lo = 13'sd1 - bias13 - $signed({7'd0, cfg.m});
      s2_in.sign = s1_sign_ff;
      if (s1_be_ff == 11'd0) begin
         s2_in.mm = {1'b0, s1_fr_ff} << s1_n_ff;
         i_c = -13'sd1022 - $signed({7'd0, s1_n_ff});
      end else begin
         s2_in.mm = {1'b1, s1_fr_ff};
         i_c = $signed({2'b00, s1_be_ff}) - 13'sd1023;
      end
      s2_in.i = i_c;
      if (nan_c) begin
         s2_in.kind = KIND_NAN;
      end else if (zero_c) begin
         s2_in.kind = KIND_ZERO;
      end else if (inf_c || i_c >= thr) begin
         s2_in.kind = KIND_SAT;
      end else if (i_c < lo) begin
         s2_in.kind = KIND_ZERO;
      end else begin
         s2_in.kind = KIND_FINITE;
      end
      s2_in.sub = i_c < (13'sd1 - bias13);
      if (s2_in.sub) begin
         s2_in.sh = 6'(lo - i_c + 13'sd52);
      end else begin
         s2_in.sh = 6'd52 - cfg.m;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (s1_adv) begin
         s1_sign_ff <= in_bits[SRC_SIGN_POS];
         s1_be_ff <= in_bits[62:52];
         s1_fr_ff <= in_bits[51:0];
         s1_n_ff <= s1_n_in;
      end
      if (s2_adv) begin
         s2_ff <= s2_in;
      end
   end

endmodule

@@ rtl/b64cf_round.sv @@
`timescale 1ns / 1ps
module b64cf_round import b64cf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    in_valid,
   output logic    in_stall,
   input  dec_type in_dec,
   output logic    out_valid,
   input  logic    out_stall,
   output rnd_type out_rnd
);

   logic               s3_valid_ff, s3_valid_in;
   logic               s3_sign_ff;
   kind_type           s3_kind_ff;
   logic [52:0]        s3_k_ff;
   logic               s3_inc_ff, s3_inc_in;
   logic               s3_exact_ff;
   logic signed [12:0] s3_i_ff;
   logic               s3_sub_ff;
   logic [5:0]         s3_sh_ff;
   logic               s4_valid_ff, s4_valid_in;
   rnd_type            s4_ff, s4_in;
   logic               s3_adv, s4_adv;

   logic [105:0] ext;
   logic         g, st, inexact;
   logic [53:0]  kinc, mshift;
   logic [11:0]  ebiased;
   logic [63:0]  mag;
   logic         ovf;

   assign s4_adv = !s4_valid_ff || !out_stall;
   assign s3_adv = !s3_valid_ff || s4_adv;
   assign in_stall = !s3_adv;
   assign out_valid = s4_valid_ff;
   assign out_rnd = s4_ff;

   always_comb begin
      ext = {in_dec.mm, 53'd0} >> in_dec.sh;
      g = ext[52];
      st = |ext[51:0];
      inexact = g || st;
      case (cfg.mode)
         RM_RNE: s3_inc_in = g && (st || ext[53]);
         RM_RTZ: s3_inc_in = 1'b0;
         RM_RDN: s3_inc_in = inexact && in_dec.sign;
         RM_RUP: s3_inc_in = inexact && !in_dec.sign;
         RM_RMM: s3_inc_in = g;
         default: s3_inc_in = g && (st || ext[53]);
      endcase
      s3_valid_in = s3_adv ? in_valid : s3_valid_ff;
      s4_valid_in = s4_adv ? s3_valid_ff : s4_valid_ff;
   end

   always_comb begin
      kinc = {1'b0, s3_k_ff} + {53'd0, s3_inc_ff};
      ebiased = 12'(s3_i_ff + $signed({2'b00, cfg.bias}) - 13'sd1);
      if (s3_sub_ff) begin
         mag = {10'd0, kinc};
      end else begin
         mag = ({52'd0, ebiased} << cfg.m) + {10'd0, kinc};
      end
      ovf = (mag >> cfg.m) >= {53'd0, all_ones(cfg.e)};
      mshift = kinc << s3_sh_ff;
      s4_in.sign = s3_sign_ff;
      s4_in.kind = (s3_kind_ff == KIND_FINITE && ovf) ? KIND_SAT : s3_kind_ff;
      s4_in.target = sign_at(s3_sign_ff, cfg.tb) + mag;
      s4_in.exact = s3_exact_ff && (s3_kind_ff == KIND_FINITE);
      if (mshift[53]) begin
         s4_in.mant = {1'b1, 52'd0};
         s4_in.xe = s3_i_ff + 13'sd1;
      end else begin
         s4_in.mant = mshift[52:0];
         s4_in.xe = s3_i_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
      if (s3_adv) begin
         s3_sign_ff <= in_dec.sign;
         s3_kind_ff <= in_dec.kind;
         s3_k_ff <= ext[105:53];
         s3_inc_ff <= s3_inc_in;
         s3_exact_ff <= !inexact;
         s3_i_ff <= in_dec.i;
         s3_sub_ff <= in_dec.sub;
         s3_sh_ff <= in_dec.sh;
      end
      if (s4_adv) begin
         s4_ff <= s4_in;
      end
   end

endmodule

@@ rtl/b64cf_pack.sv @@
`timescale 1ns / 1ps
module b64cf_pack import b64cf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        in_valid,
   output logic        in_stall,
   input  rnd_type     in_rnd,
   output logic        out_valid,
   input  logic        out_stall,
   output logic [63:0] out_target_bits,
   output logic        out_is_exact,
   output logic [63:0] out_rounded_value
);

   logic        valid_ff, valid_in, adv;
   logic [63:0] target_ff, target_in;
   logic        exact_ff, exact_in;
   logic [63:0] rounded_ff, rounded_in;
   logic [63:0] signpos, inf_pat;
   logic [52:0] sub_mant;
   logic [12:0] sub_sh;

   assign adv = !valid_ff || !out_stall;
   assign in_stall = !adv;
   assign out_valid = valid_ff;
   assign out_target_bits = target_ff;
   assign out_is_exact = exact_ff;
   assign out_rounded_value = rounded_ff;

   always_comb begin
      signpos = sign_at(in_rnd.sign, cfg.tb);
      inf_pat = signpos + ({53'd0, all_ones(cfg.e)} << cfg.m);
      sub_sh = 13'(-13'sd1022 - in_rnd.xe);
      sub_mant = (sub_sh > 13'd52) ? 53'd0 : (in_rnd.mant >> sub_sh[5:0]);
      valid_in = adv ? in_valid : valid_ff;
      exact_in = in_rnd.exact;
      case (in_rnd.kind)
         KIND_NAN: begin
            target_in = inf_pat + (64'd1 << (cfg.m - 6'd1));
            rounded_in = {in_rnd.sign, B64_QNAN_MAG};
         end
         KIND_ZERO: begin
            target_in = signpos;
            rounded_in = {in_rnd.sign, 63'd0};
         end
         KIND_SAT: begin
            target_in = inf_pat;
            rounded_in = {in_rnd.sign, B64_INF_MAG};
         end
         default: begin
            target_in = in_rnd.target;
            if (in_rnd.xe > 13'sd1023) begin
               rounded_in = {in_rnd.sign, B64_INF_MAG};
            end else if (in_rnd.xe >= -13'sd1022) begin
               rounded_in = {in_rnd.sign, 11'(in_rnd.xe + 13'sd1023), in_rnd.mant[51:0]};
            end else begin
               rounded_in = {in_rnd.sign, 11'd0, sub_mant[51:0]};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (adv) begin
         target_ff <= target_in;
         exact_ff <= exact_in;
         rounded_ff <= rounded_in;
      end
   end

endmodule

@@ rtl/binary64_to_custom_float_round.sv @@
`timescale 1ns / 1ps
// Converts each binary64 item to a sign/exponent/fraction format set by the csr registers,
// rounding in the selected mode, and also returns an exact flag and the rounded value as
// binary64. The pipeline has five register stages; a new item is taken every cycle unless
// the result side stalls, and the stall is passed back through each stage only where that
// stage holds an item.
module binary64_to_custom_float_round import b64cf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_source_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_target_bits,
   output logic        rsp_is_exact,
   output logic [63:0] rsp_rounded_value,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [6:0]  total_ff;
   logic [3:0]  exp_ff;
   logic [5:0]  mant_ff;
   logic [10:0] bias_ff;
   logic [2:0]  mode_ff;
   logic [2:0]  reg_index;
   logic        wr_en;
   cfg_type     cfg;
   logic        dec_valid, dec_stall, rnd_valid, rnd_stall;
   dec_type     dec;
   rnd_type     rnd;

   assign csr_pready = 1'b1;
   assign reg_index = csr_paddr[4:2];
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (reg_index)
         REG_TOTAL_BITS: csr_prdata = {25'd0, total_ff};
         REG_EXPONENT_BITS: csr_prdata = {28'd0, exp_ff};
         REG_MANTISSA_BITS: csr_prdata = {26'd0, mant_ff};
         REG_EXPONENT_BIAS: csr_prdata = {21'd0, bias_ff};
         REG_ROUNDING_MODE: csr_prdata = {29'd0, mode_ff};
         default: csr_prdata = 32'd0;
      endcase
      cfg.tb = (total_ff < 7'd4) ? 7'd4 : ((total_ff > 7'd64) ? 7'd64 : total_ff);
      cfg.e = (exp_ff < 4'd2) ? 4'd2 : ((exp_ff > 4'd11) ? 4'd11 : exp_ff);
      cfg.m = (mant_ff < 6'd1) ? 6'd1 : ((mant_ff > 6'd52) ? 6'd52 : mant_ff);
      cfg.bias = bias_ff;
      cfg.mode = (mode_ff > 3'd4) ? RM_RNE : mode_type'(mode_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= 7'd32;
         exp_ff <= 4'd8;
         mant_ff <= 6'd23;
         bias_ff <= 11'd127;
         mode_ff <= 3'd0;
      end else if (wr_en) begin
         case (reg_index)
            REG_TOTAL_BITS: total_ff <= csr_pwdata[6:0];
            REG_EXPONENT_BITS: exp_ff <= csr_pwdata[3:0];
            REG_MANTISSA_BITS: mant_ff <= csr_pwdata[5:0];
            REG_EXPONENT_BIAS: bias_ff <= csr_pwdata[10:0];
            REG_ROUNDING_MODE: mode_ff <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   b64cf_decode u_decode (
      .clock(clock), .reset(reset), .cfg(cfg),
      .in_valid(req_valid), .in_stall(req_stall), .in_bits(req_source_bits),
      .out_valid(dec_valid), .out_stall(dec_stall), .out_dec(dec)
   );

   b64cf_round u_round (
      .clock(clock), .reset(reset), .cfg(cfg),
      .in_valid(dec_valid), .in_stall(dec_stall), .in_dec(dec),
      .out_valid(rnd_valid), .out_stall(rnd_stall), .out_rnd(rnd)
   );

   b64cf_pack u_pack (
      .clock(clock), .reset(reset), .cfg(cfg),
      .in_valid(rnd_valid), .in_stall(rnd_stall), .in_rnd(rnd),
      .out_valid(rsp_valid), .out_stall(rsp_stall),
      .out_target_bits(rsp_target_bits), .out_is_exact(rsp_is_exact),
      .out_rounded_value(rsp_rounded_value)
   );

`ifndef SYNTHESIS
   a_exact_not_nan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_exact |->
         !(rsp_rounded_value[62:52] == 11'h7FF && rsp_rounded_value[51:0] != 52'd0))
      else $error("exact item reported with a NaN rounded value");

   a_no_stall_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled although the result side is free");
`endif

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
   import b64cf_pkg::*;

   typedef struct {
      logic [63:0] target;
      logic        exact;
      logic [63:0] rounded;
   } narrow_result_t;

   localparam int IDLE_LIMIT = 5000;
   localparam logic [63:0] FRAC52 = 64'h000F_FFFF_FFFF_FFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_source_bits = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_target_bits;
   logic        rsp_is_exact;
   logic [63:0] rsp_rounded_value;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic [6:0]  fmt_total = 7'd32;
   logic [3:0]  fmt_exp = 4'd8;
   logic [5:0]  fmt_mant = 6'd23;
   logic [10:0] fmt_bias = 11'd127;
   logic [2:0]  fmt_mode = RM_RNE;

   logic [63:0]    pending_sources[$];
   narrow_result_t expected_results[$];
   int errors = 0;
   int results_seen = 0;
   int idle_cycles = 0;
   int send_gap = 0;
   int stall_left = 0;
   int calm_left = 0;
   int hold_left = 0;
   bit hold_done = 0;

   binary64_to_custom_float_round DUT (.*);

   always #5 clock = ~clock;

   function automatic narrow_result_t narrow_b64(input logic [63:0] x);
      narrow_result_t res;
      logic s, sub, inc;
      longint unsigned fr, mm, k, r, half, mag, signpos, expones, sig;
      int be, e, m, tb, bias, thr, lo, q, i, qe, sh, p, xe, md;
      s = x[63];
      be = int'(x[62:52]);
      fr = x & FRAC52;
      e = (fmt_exp < 2) ? 2 : (fmt_exp > 11) ? 11 : int'(fmt_exp);
      m = (fmt_mant < 1) ? 1 : (fmt_mant > 52) ? 52 : int'(fmt_mant);
      tb = (fmt_total < 4) ? 4 : (fmt_total > 64) ? 64 : int'(fmt_total);
      bias = int'(fmt_bias);
      md = (fmt_mode > RM_RMM) ? int'(RM_RNE) : int'(fmt_mode);
      signpos = 64'(s) << (tb - 1);
      expones = (64'd1 << e) - 1;
      thr = int'(expones) - bias;
      lo = 1 - bias - m;
      res.exact = 1'b0;
      if (be == 2047 && fr != 0) begin
         res.target = signpos + (expones << m) + (64'd1 << (m - 1));
         res.rounded = {s, B64_QNAN_MAG};
         return res;
      end
      if (be == 0 && fr == 0) begin
         res.target = signpos;
         res.rounded = {s, 63'd0};
         return res;
      end
      if (be == 2047) begin
         i = thr;
         mm = 0;
         q = 0;
      end else if (be == 0) begin
         mm = fr;
         q = -1074;
         while ((mm >> 52) == 0) begin
            mm = mm << 1;
            q--;
         end
         i = q + 52;
      end else begin
         mm = fr | (64'd1 << 52);
         q = be - 1075;
         i = q + 52;
      end
      if (i >= thr) begin
         res.target = signpos + (expones << m);
         res.rounded = {s, B64_INF_MAG};
         return res;
      end
      if (i < lo) begin
         res.target = signpos;
         res.rounded = {s, 63'd0};
         return res;
      end
      sub = i < 1 - bias;
      qe = sub ? lo : i - m;
      sh = qe - q;
      k = mm >> sh;
      r = mm & ((64'd1 << sh) - 1);
      half = (sh > 0) ? (64'd1 << (sh - 1)) : 0;
      case (md)
         RM_RNE: inc = (r > half) || (r != 0 && r == half && k[0]);
         RM_RTZ: inc = 1'b0;
         RM_RDN: inc = (r != 0) && s;
         RM_RUP: inc = (r != 0) && !s;
         default: inc = (r != 0) && (r >= half);
      endcase
      if (inc) k = k + 1;
      mag = (sub ? 64'd0 : (64'(i + bias - 1) << m)) + k;
      res.target = signpos + mag;
      res.exact = (r == 0);
      if ((mag >> m) >= expones) begin
         res.rounded = {s, B64_INF_MAG};
         return res;
      end
      p = 0;
      while (p < 63 && (k >> (p + 1)) != 0) p++;
      xe = p + qe;
      if (xe > 1023) begin
         res.rounded = {s, B64_INF_MAG};
      end else if (xe >= -1022) begin
         sig = (p <= 52) ? (k << (52 - p)) : (k >> (p - 52));
         res.rounded = {s, 63'd0} | (64'(xe + 1023) << 52) | (sig & FRAC52);
      end else if (qe + 1074 >= 0) begin
         res.rounded = {s, 63'd0} | ((qe + 1074 < 64) ? (k << (qe + 1074)) : 64'd0);
      end else begin
         res.rounded = {s, 63'd0} | ((-1074 - qe < 64) ? (k >> (-1074 - qe)) : 64'd0);
      end
      return res;
   endfunction

   function automatic logic [63:0] pick_source();
      logic [63:0] x;
      int sel, e, m, bias, thr, lo, ee, be, w;
      sel = $urandom_range(0, 99);
      x = {$urandom, $urandom};
      if (sel < 6) return x;
      if (sel < 10) begin
         case ($urandom_range(0, 3))
            0: return {x[63], 63'd0};
            1: return {x[63], B64_INF_MAG};
            2: return {x[63], 11'h7FF, 1'b1, x[50:0]};
            default: return {x[63], 11'd0, x[51:0]};
         endcase
      end
      e = (fmt_exp < 2) ? 2 : (fmt_exp > 11) ? 11 : int'(fmt_exp);
      m = (fmt_mant < 1) ? 1 : (fmt_mant > 52) ? 52 : int'(fmt_mant);
      bias = int'(fmt_bias);
      thr = (1 << e) - 1 - bias;
      lo = 1 - bias - m;
      ee = lo - 2 + int'($urandom_range(0, thr + 1 - (lo - 2)));
      be = ee + 1023;
      be = (be < 1) ? 1 : (be > 2046) ? 2046 : be;
      x[62:52] = 11'(be);
      w = 52 - m;
      if (w > 0) begin
         case ($urandom_range(0, 3))
            0: x = x & ~((64'd1 << w) - 1);
            1: x = (x & ~((64'd1 << w) - 1)) | (64'd1 << (w - 1));
            default: ;
         endcase
      end
      return x;
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_TOTAL_BITS: fmt_total = value[6:0];
         REG_EXPONENT_BITS: fmt_exp = value[3:0];
         REG_MANTISSA_BITS: fmt_mant = value[5:0];
         REG_EXPONENT_BIAS: fmt_bias = value[10:0];
         default: fmt_mode = value[2:0];
      endcase
   endtask

   task automatic wait_drained();
      while (pending_sources.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_format(input int tb, input int e, input int m, input int bias,
                             input int mode, input int count);
      wait_drained();
      csr_write(REG_TOTAL_BITS, 32'(tb));
      csr_write(REG_EXPONENT_BITS, 32'(e));
      csr_write(REG_MANTISSA_BITS, 32'(m));
      csr_write(REG_EXPONENT_BIAS, 32'(bias));
      csr_write(REG_ROUNDING_MODE, 32'(mode));
      @(posedge clock);
      for (int n = 0; n < count; n++) pending_sources.push_back(pick_source());
   endtask

   task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
      errors++;
      $display("mismatch on %s: got %h, expected %h", field, got, want);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) expected_results.push_back(narrow_b64(req_source_bits));
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_sources.size() != 0) begin
            req_valid <= 1'b1;
            req_source_bits <= pending_sources.pop_front();
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5: send_gap = $urandom_range(1, 3);
               6: send_gap = $urandom_range(10, 40);
               default: send_gap = 0;
            endcase
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && results_seen >= 300) begin
         hold_done = 1;
         hold_left = 400;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (calm_left > 0) begin
         calm_left--;
         rsp_stall <= 1'b0;
      end else begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3: rsp_stall <= 1'b1;
            4: begin
               stall_left = $urandom_range(5, 40);
               rsp_stall <= 1'b1;
            end
            5: begin
               calm_left = $urandom_range(20, 80);
               rsp_stall <= 1'b0;
            end
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      narrow_result_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            report("unexpected item", rsp_target_bits, 64'd0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_target_bits !== want.target)
               report("target_bits", rsp_target_bits, want.target);
            if (rsp_is_exact !== want.exact)
               report("is_exact", 64'(rsp_is_exact), 64'(want.exact));
            if (rsp_rounded_value !== want.rounded)
               report("rounded_value", rsp_rounded_value, want.rounded);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("binary64_to_custom_float_round test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      pending_sources = {64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                         64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                         64'h7FF8_0000_0000_0000, 64'hFFF0_0000_0000_0001,
                         64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
                         64'h000F_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF,
                         64'h3FF0_0000_0000_0000, 64'h3FF0_0000_1000_0000,
                         64'h3FF0_0000_3000_0000, 64'hBFF0_0000_1000_0001,
                         64'h47EF_FFFF_F000_0000, 64'hC7EF_FFFF_E000_0000,
                         64'h47F0_0000_0000_0000, 64'h3810_0000_0000_0000,
                         64'h36A0_0000_0000_0000, 64'h3690_0000_0000_0000,
                         64'h3690_0000_0000_0001, 64'h380F_FFFF_F000_0000,
                         64'hB80F_FFFF_E000_0001};
      run_format(32, 8, 23, 127, RM_RNE, 80);
      run_format(32, 8, 23, 127, RM_RTZ, 100);
      run_format(32, 8, 23, 127, RM_RDN, 100);
      run_format(32, 8, 23, 127, RM_RUP, 100);
      run_format(32, 8, 23, 127, RM_RMM, 100);
      run_format(16, 5, 10, 15, RM_RUP, 120);
      run_format(16, 8, 7, 127, RM_RMM, 120);
      run_format(8, 4, 3, 7, RM_RDN, 150);
      run_format(4, 2, 1, 1, RM_RNE, 150);
      run_format(64, 11, 52, 1023, RM_RTZ, 150);
      run_format(64, 11, 52, 0, RM_RNE, 120);
      run_format(20, 3, 20, 0, 5, 150);
      run_format(0, 15, 63, 2047, 7, 150);
      run_format(127, 0, 0, 3, 6, 150);
      run_format(10, 6, 3, 2047, RM_RUP, 120);
      wait_drained();
      if (errors == 0) begin
         $display("binary64_to_custom_float_round test passed");
      end else begin
         $display("binary64_to_custom_float_round test failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/b64cf_pkg.sv
rtl/b64cf_decode.sv
rtl/b64cf_round.sv
rtl/b64cf_pack.sv
rtl/binary64_to_custom_float_round.sv
dv/testbench.sv
